FILE: src/keyed_cache_byte_budget_evict_defines.svh
// Assertion helpers for the top-level file, which checks itself.
`ifndef KEYED_CACHE_BYTE_BUDGET_EVICT_DEFINES_SVH
`define KEYED_CACHE_BYTE_BUDGET_EVICT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define KCBE_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define KCBE_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: src/kcbe_pkg.sv
package kcbe_pkg;

  localparam int MAX_ENTRIES  = 256;
  localparam int LINE_BYTES   = 64;
  localparam int HEADER_BYTES = 64;
  localparam int IDX_W        = $clog2(MAX_ENTRIES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int LINE_SH      = $clog2(LINE_BYTES);
  localparam int LINES_MAX    = 63;
  localparam int EVICT_MAX    = 63;
  localparam int Q_DEPTH      = 2;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
  // header + payload + rounding never exceeds this width
  localparam int SUM_W        = 13;
  localparam logic [SUM_W-1:0] LINE_MASK = ~SUM_W'(LINE_BYTES - 1);

  typedef enum logic [2:0] {
    ST_MISS   = 3'd0,
    ST_HIT    = 3'd1,
    ST_NEW    = 3'd2,
    ST_REPL   = 3'd3,
    ST_EVICT  = 3'd4,
    ST_REJECT = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_MODE     = 2'd1,
    CFG_BUCKETS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [20:0] capacity;
    logic        mode;
    logic [15:0] buckets;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [63:0] key;
    logic [5:0]  lines;
    logic [11:0] esize;
    logic        reject;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] key;
    logic [11:0] ebytes;
    logic [20:0] used;
    logic        last;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [11:0] line_bytes(input logic [5:0] lines);
    logic [13:0] t;
    t = 14'(lines) << LINE_SH;
    return t[11:0];
  endfunction

endpackage

FILE: src/kcbe_ram.sv
module kcbe_ram #(
  parameter int W = 32,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/kcbe_mod.sv
module kcbe_mod
  import kcbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] rem
);

  logic        run_r;
  logic [6:0]  cnt_r;
  logic [63:0] num_r;
  logic [15:0] rem_r;
  logic        done_r;
  logic [16:0] t;
  logic [16:0] t_nxt;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    t = {rem_r, num_r[63]};
    t_nxt = (t >= {1'b0, divisor}) ? t - {1'b0, divisor} : t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        num_r <= dividend;
        rem_r <= '0;
      end else if (run_r) begin
        rem_r <= t_nxt[15:0];
        num_r <= {num_r[62:0], 1'b0};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: src/kcbe_front.sv
module kcbe_front
  import kcbe_pkg::*;
(
  input  logic        in_op,
  input  logic [63:0] in_key,
  input  logic [11:0] in_value_size,
  input  logic [20:0] capacity,
  output cmd_t        cmd
);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] esize;
  logic [SUM_W-1:0] lines;

  // round header plus payload up to whole lines and classify the insert
  always_comb begin
    sum   = SUM_W'(HEADER_BYTES) + SUM_W'(in_value_size) + SUM_W'(LINE_BYTES - 1);
    esize = sum & LINE_MASK;
    lines = sum >> LINE_SH;
    cmd.op     = in_op;
    cmd.key    = in_key;
    cmd.lines  = lines[5:0];
    cmd.esize  = esize[SUM_W-1] ? 12'hFFF : esize[11:0];
    cmd.reject = in_op && ((lines > SUM_W'(LINES_MAX)) || esize[SUM_W-1] ||
                           (21'(esize) > capacity));
  end

endmodule

FILE: src/kcbe_fifo.sv
module kcbe_fifo
  import kcbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    din,
  input  logic    pop,
  output cmd_t    dout,
  output q_stat_t stat
);

  localparam int PW = $clog2(Q_DEPTH);

  cmd_t          mem_r [Q_DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [PW:0]   cnt_r;

  // hold queued commands between the classifier and the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= din;
        wp_r <= (wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assign dout       = mem_r[rp_r];
  assign stat.full  = (cnt_r == (PW+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

FILE: src/kcbe_back.sv
module kcbe_back
  import kcbe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic out_ready,
  output logic out_valid,
  output res_t out_res
);

  typedef struct packed {
    logic [63:0] key;
    logic [5:0]  lines;
    logic [31:0] istamp;
  } ment_t;

  typedef enum logic [3:0] {
    S_IDLE, S_K_RD, S_K_EV, S_K_DONE, S_E_CHK, S_V_BMOD, S_V_RD, S_V_EV,
    S_V_KMOD, S_V_DONE, S_F_START, S_F_SCAN, S_EMIT
  } state_t;

  state_t           state_r, ret_r;
  cmd_t             cmd_r;
  logic [IDX_W-1:0] idx_r, fidx_r, best_idx_r;
  logic             found_r, best_vld_r;
  logic [5:0]       flines_r, best_lines_r;
  logic [63:0]      best_key_r;
  logic [31:0]      best_age_r;
  logic [15:0]      best_dist_r, b_r;
  logic [5:0]       k_r;
  logic [31:0]      lfsr_r, stamp_r;
  logic [20:0]      bytes_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MAX_ENTRIES-1:0] valid_r;
  status_t          istat_r;
  res_t             res_r, out_r;
  logic             out_vld_r;
  logic             mw_we_r, rw_we_r;
  logic [IDX_W-1:0] w_addr_r;
  ment_t            mw_data_r;
  logic [31:0]      rw_data_r;
  logic             mod_start_r;
  logic [63:0]      mod_a_r;

  ment_t       mrd;
  logic [31:0] rrd;
  logic        mod_done;
  logic [15:0] mod_rem;
  logic [15:0] nb;
  logic [31:0] lfsr_nxt, age_lru, age_ins, stamp_inc;
  logic [16:0] dsum;
  logic [15:0] bkt_dist;
  logic        need, last_idx;
  logic [20:0] bytes_evict;
  logic        ins_wr, hit_wr, evict_go, mod_go, emit_go;

  kcbe_ram #(.W($bits(ment_t)), .D(MAX_ENTRIES)) u_main (
    .clk(clk), .we(mw_we_r), .waddr(w_addr_r), .wdata(mw_data_r),
    .raddr(idx_r), .rdata(mrd)
  );

  kcbe_ram #(.W(32), .D(MAX_ENTRIES)) u_recency (
    .clk(clk), .we(rw_we_r), .waddr(w_addr_r), .wdata(rw_data_r),
    .raddr(idx_r), .rdata(rrd)
  );

  kcbe_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start_r), .dividend(mod_a_r),
    .divisor(nb), .done(mod_done), .rem(mod_rem)
  );

  // ages, bucket distance and the eviction test
  always_comb begin
    nb        = (cfg.buckets == 16'd0) ? 16'd1 : cfg.buckets;
    lfsr_nxt  = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : 32'd0);
    age_lru   = stamp_r - rrd;
    age_ins   = stamp_r - mrd.istamp;
    stamp_inc = stamp_r + 32'd1;
    dsum      = {1'b0, mod_rem} + {1'b0, nb} - {1'b0, b_r};
    bkt_dist  = (dsum >= {1'b0, nb}) ? 16'(dsum - {1'b0, nb}) : dsum[15:0];
    need      = (22'(bytes_r) + 22'(cmd_r.esize) > 22'(cfg.capacity)) ||
                (cnt_r == CNT_W'(MAX_ENTRIES));
    last_idx  = (idx_r == IDX_W'(MAX_ENTRIES - 1));
    bytes_evict = bytes_r - 21'(line_bytes(best_lines_r));
    ins_wr    = (state_r == S_F_SCAN) && !valid_r[idx_r];
    hit_wr    = (state_r == S_K_DONE) && !cmd_r.op && found_r && !cfg.mode;
    evict_go  = (state_r == S_E_CHK) && (k_r < 6'(EVICT_MAX)) && need &&
                (cnt_r != '0);
    mod_go    = cfg.mode && (evict_go || (state_r == S_V_EV));
    emit_go   = (state_r == S_EMIT) && (!out_vld_r || out_ready);
  end

  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign out_valid = out_vld_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      stamp_r     <= '0;
      bytes_r     <= '0;
      lfsr_r      <= 32'd1;
      out_vld_r   <= 1'b0;
      mw_we_r     <= 1'b0;
      rw_we_r     <= 1'b0;
      mod_start_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      // strobe the RAM writes and the modulo start
      mw_we_r     <= ins_wr;
      rw_we_r     <= ins_wr || hit_wr;
      mod_start_r <= mod_go;
      // hold a result until the receiver takes it
      if (emit_go) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        // take the next command
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            found_r <= 1'b0;
            k_r     <= '0;
            idx_r   <= '0;
            if (cmd.reject) begin
              res_r <= '{ST_REJECT, cmd.key, cmd.esize, bytes_r, 1'b1};
              ret_r <= S_IDLE;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_K_RD;
            end
          end
        end
        // search for the key, skipping empty slots
        S_K_RD: begin
          if (valid_r[idx_r]) begin
            state_r <= S_K_EV;
          end else if (last_idx) begin
            state_r <= S_K_DONE;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        S_K_EV: begin
          if (mrd.key == cmd_r.key) begin
            found_r  <= 1'b1;
            fidx_r   <= idx_r;
            flines_r <= mrd.lines;
            state_r  <= S_K_DONE;
          end else if (last_idx) begin
            state_r <= S_K_DONE;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_K_RD;
          end
        end
        // finish a lookup, or drop the old entry of an insert
        S_K_DONE: begin
          if (!cmd_r.op) begin
            ret_r   <= S_IDLE;
            state_r <= S_EMIT;
            if (!found_r) begin
              res_r <= '{ST_MISS, cmd_r.key, 12'd0, bytes_r, 1'b1};
            end else begin
              res_r <= '{ST_HIT, cmd_r.key, line_bytes(flines_r), bytes_r, 1'b1};
              if (!cfg.mode) begin
                stamp_r   <= stamp_inc;
                w_addr_r  <= fidx_r;
                rw_data_r <= stamp_inc;
              end
            end
          end else begin
            istat_r <= found_r ? ST_REPL : ST_NEW;
            if (found_r) begin
              bytes_r         <= bytes_r - 21'(line_bytes(flines_r));
              valid_r[fidx_r] <= 1'b0;
              cnt_r           <= cnt_r - CNT_W'(1);
            end
            state_r <= S_E_CHK;
          end
        end
        // decide on another eviction
        S_E_CHK: begin
          if (evict_go) begin
            best_vld_r <= 1'b0;
            idx_r      <= '0;
            if (cfg.mode) begin
              lfsr_r      <= lfsr_nxt;
              mod_a_r     <= 64'(lfsr_nxt);
              state_r     <= S_V_BMOD;
            end else begin
              state_r <= S_V_RD;
            end
          end else begin
            state_r <= S_F_START;
          end
        end
        // draw the random bucket
        S_V_BMOD: begin
          if (mod_done) begin
            b_r     <= mod_rem;
            state_r <= S_V_RD;
          end
        end
        // scan live entries for the victim
        S_V_RD: begin
          if (valid_r[idx_r]) begin
            state_r <= S_V_EV;
          end else if (last_idx) begin
            state_r <= S_V_DONE;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        S_V_EV: begin
          if (cfg.mode) begin
            mod_a_r     <= mrd.key;
            state_r     <= S_V_KMOD;
          end else begin
            if (!best_vld_r || (age_lru > best_age_r)) begin
              best_vld_r   <= 1'b1;
              best_idx_r   <= idx_r;
              best_key_r   <= mrd.key;
              best_lines_r <= mrd.lines;
              best_age_r   <= age_lru;
            end
            if (last_idx) begin
              state_r <= S_V_DONE;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_V_RD;
            end
          end
        end
        S_V_KMOD: begin
          if (mod_done) begin
            if (!best_vld_r || (bkt_dist < best_dist_r) ||
                ((bkt_dist == best_dist_r) && (age_ins > best_age_r))) begin
              best_vld_r   <= 1'b1;
              best_idx_r   <= idx_r;
              best_key_r   <= mrd.key;
              best_lines_r <= mrd.lines;
              best_age_r   <= age_ins;
              best_dist_r  <= bkt_dist;
            end
            if (last_idx) begin
              state_r <= S_V_DONE;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_V_RD;
            end
          end
        end
        // drop the victim and report it
        S_V_DONE: begin
          bytes_r             <= bytes_evict;
          valid_r[best_idx_r] <= 1'b0;
          cnt_r               <= cnt_r - CNT_W'(1);
          k_r                 <= k_r + 6'd1;
          res_r <= '{ST_EVICT, best_key_r, line_bytes(best_lines_r), bytes_evict, 1'b0};
          ret_r   <= S_E_CHK;
          state_r <= S_EMIT;
        end
        // find the lowest free slot
        S_F_START: begin
          if (cnt_r == CNT_W'(MAX_ENTRIES)) begin
            res_r   <= '{istat_r, cmd_r.key, cmd_r.esize, bytes_r, 1'b1};
            ret_r   <= S_IDLE;
            state_r <= S_EMIT;
          end else begin
            idx_r   <= '0;
            state_r <= S_F_SCAN;
          end
        end
        S_F_SCAN: begin
          if (!valid_r[idx_r]) begin
            stamp_r        <= stamp_inc;
            valid_r[idx_r] <= 1'b1;
            cnt_r          <= cnt_r + CNT_W'(1);
            bytes_r        <= bytes_r + 21'(cmd_r.esize);
            w_addr_r       <= idx_r;
            mw_data_r      <= '{cmd_r.key, cmd_r.lines, stamp_inc};
            rw_data_r      <= stamp_inc;
            res_r <= '{istat_r, cmd_r.key, cmd_r.esize,
                       bytes_r + 21'(cmd_r.esize), 1'b1};
            ret_r   <= S_IDLE;
            state_r <= S_EMIT;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        // hand the result to the output register
        S_EMIT: begin
          if (emit_go) begin
            out_r     <= res_r;
            state_r   <= ret_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/keyed_cache_byte_budget_evict.sv
// Keyed cache directory with a byte budget. Each input transfer is a lookup
// or an insert; a lookup gives one result, an insert gives one eviction
// notice per victim (tlast low) and then its own result (tlast high). Items
// queue two deep ahead of a sequencer that scans the 256-slot table held in
// RAM: a lookup reads each live slot and skips each empty slot up to its
// match. An insert adds, per eviction, one full table scan (LRU: by recency;
// random: a bucket draw, then a key modulo per live slot in the bit-serial
// key-modulo unit) and a free-slot search. A result leaves through an output
// register, so the next item is accepted while one still waits. Slot valid
// bits are flip-flops cleared at reset; no clearing pass is run.
module keyed_cache_byte_budget_evict
  import kcbe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // key[63:0], value_size[75:64], zero fill
  input  logic         in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // key_out[63:0], entry_bytes[75:64],
                                   // used_bytes[96:76], zero fill
  output logic [2:0]   out_tuser,  // status
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [20:0]  cfg_data
);

`include "keyed_cache_byte_budget_evict_defines.svh"

  cfg_t    cfg_r;
  cmd_t    front_cmd, q_cmd;
  q_stat_t q_stat;
  logic    q_push, q_pop;
  logic    res_vld;
  res_t    res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity <= 21'd65536;
      cfg_r.mode     <= 1'b0;
      cfg_r.buckets  <= 16'd255;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CAPACITY: cfg_r.capacity <= cfg_data;
        CFG_MODE:     cfg_r.mode     <= cfg_data[0];
        CFG_BUCKETS:  cfg_r.buckets  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  kcbe_front u_front (
    .in_op(in_tuser), .in_key(in_tdata[63:0]), .in_value_size(in_tdata[75:64]),
    .capacity(cfg_r.capacity), .cmd(front_cmd)
  );

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready;

  kcbe_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(front_cmd),
    .pop(q_pop), .dout(q_cmd), .stat(q_stat)
  );

  kcbe_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .cmd_valid(!q_stat.empty),
    .cmd(q_cmd), .cmd_pop(q_pop), .out_ready(out_tready),
    .out_valid(res_vld), .out_res(res)
  );

  // pack the result transfer
  assign out_tvalid = res_vld;
  assign out_tuser  = res.status;
  assign out_tlast  = res.last;
  assign out_tdata  = {7'd0, res.used, res.ebytes, res.key};

  `KCBE_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full)
  `KCBE_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty)
  `KCBE_ASSERT_IMP(a_mid_is_evict, out_tvalid && !out_tlast, out_tuser == ST_EVICT)
  `KCBE_ASSERT_IMP(a_miss_zero, out_tvalid && (out_tuser == ST_MISS),
                   out_tdata[75:64] == 12'd0)

endmodule
